/* hdl/pnu_pkg.sv */
// shared types and constants for the polygonal number unit
// no dependencies; imported by the top level, the divide stage, the checker and the testbench
`default_nettype none

package pnu_pkg;

  // fixed widths of the register and of the item fields
  localparam int SIDES_W = 16;
  localparam int DEN_W   = SIDES_W + 1;
  localparam int FIELD_W = 64;

  localparam logic [SIDES_W-1:0] SIDES_MIN   = 16'd3;
  localparam logic [SIDES_W-1:0] SIDES_RESET = 16'd3;

  // command code for value to index
  localparam logic CMD_INV = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_POLY = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // per-item control bits that ride along the pipeline
  typedef struct packed {
    logic cmd;
    logic zero;
    logic bad;
  } item_flags_t;

endpackage

`default_nettype wire

/* hdl/pnu_fwd_stage.sv */
// one shift-add step of the forward product acc * n with a sticky overflow
// standalone stage, no package use
`default_nettype none

module pnu_fwd_stage #(
  parameter int W   = 64,
  parameter int AW  = 81,
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [AW-1:0] acc_in,
  input  logic [W-1:0]  n_in,
  input  logic [W+1:0]  sum_in,
  input  logic          ovf_in,
  output logic [AW-1:0] acc_out,
  output logic [W-1:0]  n_out,
  output logic [W+1:0]  sum_out,
  output logic          ovf_out
);

  logic [AW-1:0] hi;
  logic          term_big;
  logic [W+1:0]  term;
  logic [W+1:0]  sum_next;

  // partial product for this bit of n; anything at or above bit W+1 overflows
  always_comb begin
    hi       = acc_in >> (W + 1 - BIT);
    term_big = n_in[BIT] && (hi != '0);
    term     = n_in[BIT] ? (W+2)'(acc_in << BIT) : '0;
    sum_next = sum_in + term;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_out <= acc_in;
      n_out   <= n_in;
      sum_out <= sum_next;
      ovf_out <= ovf_in | term_big | sum_next[W+1];
    end
  end

endmodule

`default_nettype wire

/* hdl/pnu_root_stage.sv */
// one bit of a restoring integer square root, remainder kept as d - r*r
// standalone stage, no package use
`default_nettype none

module pnu_root_stage #(
  parameter int RB  = 42,
  parameter int RW  = 85,
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [RB-1:0] root_in,
  input  logic [RW-1:0] rem_in,
  output logic [RB-1:0] root_out,
  output logic [RW-1:0] rem_out
);

  logic [RW-1:0] trial;
  logic          take;

  // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
  always_comb begin
    trial = (RW'(root_in) << (BIT + 1)) + (RW'(1) << (2 * BIT));
    take  = rem_in >= trial;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_out <= take ? (root_in | (RB'(1) << BIT)) : root_in;
      rem_out  <= take ? (rem_in - trial) : rem_in;
    end
  end

endmodule

`default_nettype wire

/* hdl/pnu_div_stage.sv */
// one quotient bit of a restoring divide by the side-derived denominator
// depends on pnu_pkg for the denominator width
`default_nettype none

module pnu_div_stage #(
  parameter int QB  = 43,
  parameter int BIT = 0
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [pnu_pkg::DEN_W-1:0] den,
  input  logic [QB-1:0]             num_in,
  input  logic [pnu_pkg::DEN_W-1:0] pr_in,
  input  logic [QB-1:0]             q_in,
  output logic [QB-1:0]             num_out,
  output logic [pnu_pkg::DEN_W-1:0] pr_out,
  output logic [QB-1:0]             q_out
);
  import pnu_pkg::*;

  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic           take;

  // bring down the next numerator bit and try to subtract
  always_comb begin
    trial = {pr_in, num_in[BIT]};
    diff  = trial - {1'b0, den};
    take  = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_out <= num_in;
      pr_out  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      q_out   <= {q_in[QB-2:0], take};
    end
  end

endmodule

`default_nettype wire

/* hdl/polygonal_number_unit.sv */
// top level of the polygonal number unit: config register, pipeline, output buffer
// depends on pnu_pkg, pnu_fwd_stage, pnu_root_stage, pnu_div_stage
//
//   channel  | signals                          | direction
//   ---------+----------------------------------+----------
//   cfg      | cfg_valid cfg_ready cfg_data     | in
//   in       | in_valid in_ready cmd operand    | in
//   out      | out_valid out_ready answer status| out
//
// one item per cycle while the skid entry is empty; the pipeline depth is set by
// the one-bit-per-stage square root over RB = (DATA_WIDTH+21)/2 bits and the
// one-bit-per-stage divide.
// rst is synchronous and clears the side count to 3 and all valid bits.
// the pipeline moves as a whole; a two-entry output buffer absorbs one stalled
// result, and in_ready drops only while both entries are full.
`default_nettype none

module polygonal_number_unit #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pnu_pkg::SIDES_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        cmd,
  input  logic [pnu_pkg::FIELD_W-1:0] operand,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pnu_pkg::FIELD_W-1:0] answer,
  output logic [1:0]                  status
);
  import pnu_pkg::*;

  localparam int W      = DATA_WIDTH;
  localparam int SW     = SIDES_W;
  localparam int AW     = W + SW + 1;
  localparam int DW     = W + SW + 4;
  localparam int RB     = (W + 21) / 2;
  localparam int RW     = 2 * RB + 1;
  localparam int QB     = RB + 1;
  localparam int PAD    = 2 * RB + 2 - W;
  localparam int LAT    = 2 * RB + 5;
  localparam int S_NUM  = RB + 3;

  // side count register and values derived from it
  logic [SW-1:0]    sides;
  logic [SW-1:0]    k_s;
  logic [SW-1:0]    off;
  logic [SW+2:0]    k8;
  logic [DEN_W-1:0] den;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sides <= SIDES_RESET;
    end else if (cfg_valid && cfg_data >= SIDES_MIN) begin
      sides <= cfg_data;
    end
  end

  assign k_s = sides - SW'(2);
  assign off = (sides >= SW'(4)) ? sides - SW'(4) : SW'(1);
  assign k8  = {k_s, 3'b000};
  assign den = DEN_W'({sides, 1'b0}) - DEN_W'(4);

  // pipeline advance and valid bits
  logic               en;
  logic               push;
  logic [LAT-1:1]     vld;
  item_flags_t        flg [1:LAT-1];
  logic               skid_vld;

  // square root stages, remainder and partial root
  logic [RW-1:0] rt_rem  [RB+1];
  logic [RB-1:0] rt_root [RB+1];

  assign en       = !skid_vld;
  assign in_ready = !skid_vld;
  assign push     = en && vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld[1] <= in_valid;
      for (int s = 2; s < LAT; s++) begin
        vld[s] <= vld[s-1];
      end
    end
  end

  // first two stages: products, then sums
  logic [W-1:0]    fwd_m;
  logic [W-1:0]    n1;
  logic [W-1:0]    n2;
  logic [W+SW-1:0] fa1;
  logic [AW-1:0]   acc2;
  logic [W+SW+2:0] p1;
  logic [2*SW-1:0] p2;
  logic [DW-1:0]   d2;

  assign fwd_m = operand[W-1:0] - W'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      n1     <= operand[W-1:0];
      fa1    <= (W+SW)'(k_s) * (W+SW)'(fwd_m);
      p1     <= (W+SW+3)'(k8) * (W+SW+3)'(operand[W-1:0]);
      p2     <= (2*SW)'(off) * (2*SW)'(off);
      flg[1] <= '{cmd: cmd, zero: (operand[W-1:0] == '0), bad: 1'b0};
      n2     <= n1;
      acc2   <= AW'(fa1) + AW'(2);
      d2     <= DW'(p1) + DW'(p2);
    end
  end

  // flags ride along; the root exactness is noted after the last root bit
  for (genvar s = 2; s < LAT; s++) begin : g_flags
    if (s == S_NUM) begin : g_bad
      always_ff @(posedge clk) begin
        if (en) begin
          flg[s] <= '{cmd: flg[s-1].cmd, zero: flg[s-1].zero,
                      bad: (rt_rem[RB] != '0)};
        end
      end
    end else begin : g_copy
      always_ff @(posedge clk) begin
        if (en) begin
          flg[s] <= flg[s-1];
        end
      end
    end
  end

  // forward path: shift-add over the bits of n, then delay to align
  logic [AW-1:0] f_acc [W+1];
  logic [W-1:0]  f_n   [W+1];
  logic [W+1:0]  f_sum [W+1];
  logic          f_ovf [W+1];

  assign f_acc[0] = acc2;
  assign f_n[0]   = n2;
  assign f_sum[0] = '0;
  assign f_ovf[0] = 1'b0;

  for (genvar i = 0; i < W; i++) begin : g_fwd
    pnu_fwd_stage #(.W(W), .AW(AW), .BIT(i)) u_fwd (
      .clk     (clk),
      .en      (en),
      .acc_in  (f_acc[i]),
      .n_in    (f_n[i]),
      .sum_in  (f_sum[i]),
      .ovf_in  (f_ovf[i]),
      .acc_out (f_acc[i+1]),
      .n_out   (f_n[i+1]),
      .sum_out (f_sum[i+1]),
      .ovf_out (f_ovf[i+1])
    );
  end

  logic [W+1:0] pd_sum [PAD+1];
  logic         pd_ovf [PAD+1];

  assign pd_sum[0] = f_sum[W];
  assign pd_ovf[0] = f_ovf[W];

  for (genvar p = 0; p < PAD; p++) begin : g_pad
    always_ff @(posedge clk) begin
      if (en) begin
        pd_sum[p+1] <= pd_sum[p];
        pd_ovf[p+1] <= pd_ovf[p];
      end
    end
  end

  // inverse path: square root of d, one bit per stage
  assign rt_rem[0]  = RW'(d2);
  assign rt_root[0] = '0;

  for (genvar k = 0; k < RB; k++) begin : g_root
    pnu_root_stage #(.RB(RB), .RW(RW), .BIT(RB - 1 - k)) u_root (
      .clk      (clk),
      .en       (en),
      .root_in  (rt_root[k]),
      .rem_in   (rt_rem[k]),
      .root_out (rt_root[k+1]),
      .rem_out  (rt_rem[k+1])
    );
  end

  // numerator r + s - 4
  logic [QB-1:0] num_q;

  always_ff @(posedge clk) begin
    if (en) begin
      num_q <= QB'((QB+1)'(rt_root[RB]) + (QB+1)'(sides) - (QB+1)'(4));
    end
  end

  // divide by 2s - 4, one quotient bit per stage
  logic [QB-1:0]    dv_num [QB+1];
  logic [DEN_W-1:0] dv_pr  [QB+1];
  logic [QB-1:0]    dv_q   [QB+1];

  assign dv_num[0] = num_q;
  assign dv_pr[0]  = '0;
  assign dv_q[0]   = '0;

  for (genvar k = 0; k < QB; k++) begin : g_div
    pnu_div_stage #(.QB(QB), .BIT(QB - 1 - k)) u_div (
      .clk     (clk),
      .en      (en),
      .den     (den),
      .num_in  (dv_num[k]),
      .pr_in   (dv_pr[k]),
      .q_in    (dv_q[k]),
      .num_out (dv_num[k+1]),
      .pr_out  (dv_pr[k+1]),
      .q_out   (dv_q[k+1])
    );
  end

  // result selection for the item leaving the pipeline
  logic [FIELD_W-1:0] res_ans;
  status_t            res_st;

  always_comb begin
    res_ans = '0;
    res_st  = ST_OK;
    if (flg[LAT-1].cmd == CMD_INV) begin
      if (flg[LAT-1].zero) begin
        res_st = ST_OK;
      end else if (flg[LAT-1].bad || dv_pr[QB] != '0) begin
        res_st = ST_NOT_POLY;
      end else begin
        res_ans = FIELD_W'(dv_q[QB]);
      end
    end else begin
      if (pd_ovf[PAD]) begin
        res_st = ST_OVERFLOW;
      end else begin
        res_ans = FIELD_W'(pd_sum[PAD][W:1]);
      end
    end
  end

  // output register plus skid entry
  logic [FIELD_W-1:0] skid_ans;
  status_t            skid_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_vld  <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_vld) begin
        out_valid <= 1'b1;
        skid_vld  <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_vld) begin
        answer <= skid_ans;
        status <= skid_st;
      end else begin
        answer <= res_ans;
        status <= res_st;
      end
    end else if (push) begin
      skid_ans <= res_ans;
      skid_st  <= res_st;
    end
  end

  // checks
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (answer == '0))
    else $error("nonzero answer with error status");

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled while output register empty");

  a_sides_min: assert property (@(posedge clk) disable iff (rst)
    sides >= SIDES_MIN)
    else $error("side count below three");

  a_skid_load: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_vld) |-> $past(out_valid && !out_ready))
    else $error("skid entry filled while output was free");

endmodule

`default_nettype wire

/* verif/pnu_checker.sv */
// checker for the polygonal number unit: tracks the side count, predicts each
// result from the accepted items and compares the output items in order
// depends on pnu_pkg
`timescale 1ns / 100ps

module pnu_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        cmd,
  input  logic [63:0] operand,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] answer,
  input  logic [1:0]  status,
  output int          fail_count,
  output int          pending
);
  import pnu_pkg::*;

  typedef struct {
    logic [63:0] answer;
    status_t     status;
  } figurate_t;

  figurate_t   figurate_q[$];
  logic [15:0] side_count;

  // exact figurate evaluation in either direction
  function automatic figurate_t eval_figurate(input logic inv, input logic [63:0] x,
                                              input logic [15:0] s);
    figurate_t   res;
    logic [191:0] acc;
    logic [127:0] disc, cand, root;
    logic [63:0]  off, num, den;
    res.answer = '0;
    res.status = ST_OK;
    if (x == 0) return res;
    if (inv != CMD_INV) begin
      acc = 192'(s - 16'd2) * 192'(x - 64'd1) + 192'd2;
      acc = (acc * 192'(x)) >> 1;
      if (acc[191:64] != 0) res.status = ST_OVERFLOW;
      else res.answer = acc[63:0];
    end else begin
      off  = (s >= 16'd4) ? 64'(s) - 64'd4 : 64'd1;
      disc = 128'(64'(s) - 64'd2) * 128'd8 * 128'(x) + 128'(off) * 128'(off);
      root = '0;
      for (int b = 43; b >= 0; b--) begin
        cand = root | (128'd1 << b);
        if (cand * cand <= disc) root = cand;
      end
      num = root[63:0] + 64'(s) - 64'd4;
      den = 64'd2 * 64'(s) - 64'd4;
      if (root * root != disc || num % den != 0) res.status = ST_NOT_POLY;
      else res.answer = num / den;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    side_count = SIDES_RESET;
  end

  // watch all three channels at each rising edge
  always @(posedge clk) begin
    figurate_t want;
    if (rst) begin
      side_count = SIDES_RESET;
    end else begin
      if (out_valid && out_ready) begin
        if (figurate_q.size() == 0) begin
          report_mismatch($sformatf("unexpected item answer=%h status=%0d", answer, status));
        end else begin
          want = figurate_q.pop_front();
          if (answer !== want.answer)
            report_mismatch($sformatf("answer %h, expected %h", answer, want.answer));
          if (status !== 2'(want.status))
            report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        end
      end
      if (in_valid && in_ready)
        figurate_q.push_back(eval_figurate(cmd, operand, side_count));
      if (cfg_valid && cfg_ready && cfg_data >= SIDES_MIN)
        side_count = cfg_data;
    end
    pending = figurate_q.size();
  end

endmodule

/* verif/polygonal_number_unit_tb.sv */
// testbench top for the polygonal number unit: clock, reset, stimulus, verdict
// depends on pnu_pkg, polygonal_number_unit and pnu_checker
`timescale 1ns / 100ps

module polygonal_number_unit_tb;
  import pnu_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_WAIT = 120;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = 1'b0;
  logic [63:0] operand = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] answer;
  logic [1:0]  status;
  int          fail_count, pending;
  int          idle_cycles = 0;
  bit          sender_bursty = 1'b0;
  logic [15:0] cur_sides = 16'd3;

  always #6 clk = ~clk;

  polygonal_number_unit u_top (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_data, .in_valid, .in_ready,
    .cmd, .operand, .out_valid, .out_ready, .answer, .status
  );

  pnu_checker u_checker (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_data, .in_valid, .in_ready,
    .cmd, .operand, .out_valid, .out_ready, .answer, .status,
    .fail_count, .pending
  );

  // short random gap, occasionally a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 2);
  endfunction

  // receiver stalls, with stretches of steady ready
  always @(negedge clk) begin
    int stall;
    if (!rst && $urandom_range(0, 49) == 0) begin
      out_ready <= 1'b1;
      repeat ($urandom_range(20, 80)) @(negedge clk);
    end else if (!rst) begin
      stall = pick_gap();
      if (stall == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no accepted item anywhere
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // drop input valid, then wait for every expected result
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // side count is only changed once the pipeline is empty
  task automatic write_sides(input logic [15:0] value);
    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (value >= SIDES_MIN) cur_sides = value;
  endtask

  // one input item; valid stays high across back-to-back items
  task automatic send_item(input logic c, input logic [63:0] op);
    int gap;
    gap = sender_bursty ? 0 : pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    operand  <= op;
    do @(posedge clk); while (!in_ready);
  endtask

  // exact figurate value for a small index, used to form well-formed inverses
  function automatic logic [63:0] small_figurate(input logic [63:0] n, input logic [15:0] s);
    return n * ((64'(s) - 64'd2) * (n - 64'd1) + 64'd2) / 64'd2;
  endfunction

  task automatic random_items(input int count);
    logic [63:0] n, op;
    int kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        op = {$urandom, $urandom} >> $urandom_range(0, 64);
        send_item(1'b0, op);
      end else if (kind < 80) begin
        n  = 64'($urandom_range(1, 1 << $urandom_range(1, 20)));
        op = small_figurate(n, cur_sides);
        if (kind >= 72) op = op + ($urandom_range(0, 1) ? 64'd1 : -64'd1);
        send_item(1'b1, op);
      end else begin
        send_item(1'b1, {$urandom, $urandom} >> $urandom_range(0, 63));
      end
    end
  endtask

  initial begin
    logic [15:0] phase_sides[10];
    phase_sides = '{16'd4, 16'd5, 16'd65535, 16'd2, 16'd0, 16'd6, 16'd1000, 16'd1, 16'd7, 16'd3};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes and special cases at the smallest and the largest side count
    write_sides(16'd3);
    send_item(1'b0, 64'd0);
    send_item(1'b0, 64'd1);
    send_item(1'b0, 64'd2);
    send_item(1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(1'b0, 64'd6074000999);
    send_item(1'b0, 64'd6074001000);
    send_item(1'b1, 64'd0);
    send_item(1'b1, 64'd1);
    send_item(1'b1, 64'd6);
    send_item(1'b1, 64'd7);
    send_item(1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(1'b1, 64'h5555_5555_5555_5555);
    send_item(1'b1, 64'hAAAA_AAAA_AAAA_AAAA);
    write_sides(16'd65535);
    send_item(1'b0, 64'd1);
    send_item(1'b0, 64'd23726566);
    send_item(1'b0, 64'hFFFF_FFFF);
    send_item(1'b1, small_figurate(64'd1000, 16'd65535));
    send_item(1'b1, small_figurate(64'd1000, 16'd65535) + 64'd1);
    send_item(1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    // rejected writes keep the old count
    write_sides(16'd2);
    send_item(1'b1, small_figurate(64'd77, 16'd65535));

    // random phases over several side counts
    for (int p = 0; p < 10; p++) begin
      write_sides(p == 9 ? 16'($urandom_range(3, 65535)) : phase_sides[p]);
      sender_bursty = (p % 3 == 1);
      random_items(35);
      if (p == 4) wait_drained();
      random_items(35);
    end

    sender_bursty = 1'b0;
    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/pnu_pkg.sv
hdl/pnu_fwd_stage.sv
hdl/pnu_root_stage.sv
hdl/pnu_div_stage.sv
hdl/polygonal_number_unit.sv
verif/pnu_checker.sv
verif/polygonal_number_unit_tb.sv
